@@ design/ssgr_pkg.sv @@
package ssgr_pkg;

  // Sample and gain formats
  localparam int SAMPLE_BITS    = 24;
  localparam int GAIN_FRAC_BITS = 28;
  localparam int GAIN_BITS      = 32;
  localparam int RATIO_BITS     = 31;
  localparam int RATIO_FRAC     = 30;
  localparam int TOL_BITS       = 29;
  localparam int COEF_BITS      = 16;
  localparam int COEF_FRAC      = 16;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 31;

  // Shared multiplier: 32 x 32 unsigned
  localparam int MUL_BITS  = 32;
  localparam int PROD_BITS = 2 * MUL_BITS;

  // Sample scaling: magnitude times gain, then rounding
  localparam int SCL_BITS = SAMPLE_BITS + GAIN_BITS;
  localparam int RND_BITS = SCL_BITS + 1 - GAIN_FRAC_BITS;

  localparam logic [GAIN_BITS-1:0] UNITY_GAIN = GAIN_BITS'(64'd1 << GAIN_FRAC_BITS);
  localparam logic [SCL_BITS:0]    ROUND_HALF = (SCL_BITS+1)'(64'd1 << (GAIN_FRAC_BITS - 1));
  localparam logic [RND_BITS-1:0]  LIM_NEG    = RND_BITS'(64'd1 << (SAMPLE_BITS - 1));
  localparam logic [RND_BITS-1:0]  LIM_POS    = RND_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Register reset values
  localparam logic [RATIO_BITS-1:0] RATIO_UP_RST   = 31'd1074205487;
  localparam logic [RATIO_BITS-1:0] RATIO_DOWN_RST = 31'd1073278365;
  localparam logic [TOL_BITS-1:0]   TOL_RST        = 29'd2684;
  localparam logic [COEF_BITS-1:0]  COEF_RST       = 16'd3277;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RATIO_UP   = 2'd0,
    CFG_RATIO_DOWN = 2'd1,
    CFG_TOLERANCE  = 2'd2,
    CFG_COEF       = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [RATIO_BITS-1:0] ratio_up;
    logic [RATIO_BITS-1:0] ratio_down;
    logic [TOL_BITS-1:0]   tolerance;
    logic [COEF_BITS-1:0]  approach_coef;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic [GAIN_BITS-1:0]          target_gain;
    logic                          jump_now;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic [GAIN_BITS-1:0]          gain_now;
    logic                          ramping;
    logic                          clipped;
  } out_item_t;

  // Request as classified by the front
  typedef struct packed {
    in_item_t item;
    logic     retarget;
  } queue_item_t;

  typedef struct packed {
    logic                          clip;
    logic signed [SAMPLE_BITS-1:0] val;
  } scaled_t;

  // Magnitude of a signed sample (most negative value maps to its own pattern)
  function automatic logic [SAMPLE_BITS-1:0] sample_mag(input logic [SAMPLE_BITS-1:0] s);
    sample_mag = s[SAMPLE_BITS-1] ? (~s + 1'b1) : s;
  endfunction

  // Round to nearest (ties away from zero) and saturate to the sample range
  function automatic scaled_t scale_round(input logic [SCL_BITS-1:0] p, input logic neg);
    logic [SCL_BITS:0]   sum;
    logic [RND_BITS-1:0] r;
    scaled_t             res;
    sum      = {1'b0, p} + ROUND_HALF;
    r        = sum[SCL_BITS:GAIN_FRAC_BITS];
    res.clip = 1'b0;
    if (neg) begin
      if (r > LIM_NEG) begin
        r        = LIM_NEG;
        res.clip = 1'b1;
      end
      res.val = ~r[SAMPLE_BITS-1:0] + 1'b1;
    end else begin
      if (r > LIM_POS) begin
        r        = LIM_POS;
        res.clip = 1'b1;
      end
      res.val = r[SAMPLE_BITS-1:0];
    end
    scale_round = res;
  endfunction

endpackage

@@ design/stereo_smooth_gain_ramp_unit.sv @@
// Stereo gain stage with a smoothed gain ramp.
// Input channel (in_valid_i / in_stall_o / in_item_i): one stereo pair, the
// target gain (Q4.28) and a jump flag per request. A request is taken on a
// clock edge with valid high and stall low.
// Output channel (out_valid_o / out_stall_i / out_item_o): one result per
// request, in order: both samples scaled and saturated, the gain applied,
// the ramping flag and a clip flag.
// Configuration: cfg_we_i writes cfg_data_i to the register at cfg_idx_i
// (ratio up, ratio down, tolerance, approach coefficient).
// A taken request passes the queue, then the back-end states error, then
// geometric, approach and update when the gain steps, then left scale,
// right scale and output. The back end takes no new request until the
// last result is written; one 32x32 multiplier serves gain step and samples.
// A two-entry queue lets the front keep accepting while the back works.
// Reset: gain and held target return to unity, no transition, registers to
// their defaults, queue and output empty.
// Stalls: a stalled result is held; the back end waits on it and the queue
// fills, after which in_stall_o rises.
module stereo_smooth_gain_ramp_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ssgr_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ssgr_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_we_i,
  input  logic [ssgr_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [ssgr_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);
  import ssgr_pkg::*;

  cfg_t        cfg_q;
  logic        q_full, q_push, q_pop, q_valid;
  queue_item_t q_push_item, q_pop_item;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ratio_up      <= RATIO_UP_RST;
      cfg_q.ratio_down    <= RATIO_DOWN_RST;
      cfg_q.tolerance     <= TOL_RST;
      cfg_q.approach_coef <= COEF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_RATIO_UP:   cfg_q.ratio_up      <= cfg_data_i[RATIO_BITS-1:0];
        CFG_RATIO_DOWN: cfg_q.ratio_down    <= cfg_data_i[RATIO_BITS-1:0];
        CFG_TOLERANCE:  cfg_q.tolerance     <= cfg_data_i[TOL_BITS-1:0];
        CFG_COEF:       cfg_q.approach_coef <= cfg_data_i[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  ssgr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_push_item)
  );

  ssgr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_item_o  (q_pop_item)
  );

  ssgr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_pop_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ design/ssgr_front.sv @@
module ssgr_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ssgr_pkg::in_item_t    in_item_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output ssgr_pkg::queue_item_t q_item_o
);
  import ssgr_pkg::*;

  // Held target follows the request stream alone: every request leaves its target
  logic [GAIN_BITS-1:0] held_d, held_q;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Classify: a new target without jump starts a transition
  always_comb begin
    q_item_o.item     = in_item_i;
    q_item_o.retarget = !in_item_i.jump_now && (in_item_i.target_gain != held_q);
    held_d            = q_push_o ? in_item_i.target_gain : held_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= UNITY_GAIN;
    end else begin
      held_q <= held_d;
    end
  end

endmodule

@@ design/ssgr_queue.sv @@
module ssgr_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ssgr_pkg::queue_item_t push_item_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output ssgr_pkg::queue_item_t pop_item_o
);
  import ssgr_pkg::*;

  queue_item_t          entry_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [QCNT_BITS-1:0] count_d, count_q;

  assign full_o     = (count_q == QCNT_BITS'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_item_o = entry_q[rd_ptr_q];

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ design/ssgr_back.sv @@
module ssgr_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ssgr_pkg::cfg_t        cfg_i,
  input  logic                  q_valid_i,
  input  ssgr_pkg::queue_item_t q_item_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ssgr_pkg::out_item_t   out_item_o
);
  import ssgr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_GEO,
    S_APP,
    S_UPD,
    S_SCL_L,
    S_SCL_R,
    S_OUT
  } state_e;

  state_e                  state_q;
  logic [GAIN_BITS-1:0]    g_q, t_q, err_q;
  logic                    trans_q, jump_q, up_q, geo_ok_q;
  logic [SAMPLE_BITS-1:0]  l_q, r_q;
  logic [PROD_BITS-1:0]    prod_q;
  logic [GAIN_BITS:0]      cand_q;
  scaled_t                 lres_q;
  out_item_t               out_q;
  logic                    out_valid_q;

  logic [MUL_BITS-1:0]     mul_a, mul_b;
  logic [PROD_BITS-1:0]    mul_p;
  logic [GAIN_BITS-1:0]    err_now, step_raw, step, g_upd;
  logic [GAIN_BITS:0]      cand_now;
  logic                    geo_ok_now, out_free;
  scaled_t                 rres;

  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Distance between gain and target
  assign err_now = (g_q > t_q) ? (g_q - t_q) : (t_q - g_q);

  // Shared multiplier operands
  always_comb begin
    unique case (state_q)
      S_GEO: begin
        mul_a = MUL_BITS'(g_q);
        mul_b = up_q ? MUL_BITS'(cfg_i.ratio_up) : MUL_BITS'(cfg_i.ratio_down);
      end
      S_APP: begin
        mul_a = MUL_BITS'(err_q);
        mul_b = MUL_BITS'(cfg_i.approach_coef);
      end
      S_SCL_L: begin
        mul_a = MUL_BITS'(sample_mag(l_q));
        mul_b = MUL_BITS'(g_q);
      end
      S_SCL_R: begin
        mul_a = MUL_BITS'(sample_mag(r_q));
        mul_b = MUL_BITS'(g_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Geometric candidate must move toward the target without passing it
  always_comb begin
    cand_now = prod_q[RATIO_FRAC +: GAIN_BITS+1];
    if (up_q) begin
      geo_ok_now = (cand_now > {1'b0, g_q}) && (cand_now <= {1'b0, t_q});
    end else begin
      geo_ok_now = (cand_now < {1'b0, g_q}) && (cand_now >= {1'b0, t_q});
    end
  end

  // Asymptotic step, at least one LSB, never past the target
  always_comb begin
    step_raw = prod_q[COEF_FRAC +: GAIN_BITS];
    step     = (step_raw == '0) ? GAIN_BITS'(1) : step_raw;
    if (step > err_q) begin
      step = err_q;
    end
    if (geo_ok_q) begin
      g_upd = cand_q[GAIN_BITS-1:0];
    end else if (up_q) begin
      g_upd = g_q + step;
    end else begin
      g_upd = g_q - step;
    end
  end

  assign rres = scale_round(prod_q[SCL_BITS-1:0], r_q[SAMPLE_BITS-1]);

  // Sequencer, gain state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      g_q         <= UNITY_GAIN;
      t_q         <= UNITY_GAIN;
      trans_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // result valid: raised from the output state, dropped once taken
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            l_q    <= q_item_i.item.left_sample;
            r_q    <= q_item_i.item.right_sample;
            t_q    <= q_item_i.item.target_gain;
            jump_q <= q_item_i.item.jump_now;
            if (q_item_i.item.jump_now) begin
              g_q     <= q_item_i.item.target_gain;
              trans_q <= 1'b0;
            end else if (q_item_i.retarget) begin
              trans_q <= 1'b1;
            end
            state_q <= S_ERR;
          end
        end
        S_ERR: begin
          err_q <= err_now;
          up_q  <= (g_q < t_q);
          if (trans_q && (err_now > GAIN_BITS'(cfg_i.tolerance))) begin
            state_q <= S_GEO;
          end else begin
            state_q <= S_SCL_L;
          end
        end
        S_GEO: begin
          prod_q  <= mul_p;
          state_q <= S_APP;
        end
        S_APP: begin
          cand_q   <= cand_now;
          geo_ok_q <= geo_ok_now;
          prod_q   <= mul_p;
          state_q  <= S_UPD;
        end
        S_UPD: begin
          g_q     <= g_upd;
          state_q <= S_SCL_L;
        end
        S_SCL_L: begin
          // transition ends once the error is within tolerance
          if (err_now <= GAIN_BITS'(cfg_i.tolerance)) begin
            trans_q <= 1'b0;
          end
          prod_q  <= mul_p;
          state_q <= S_SCL_R;
        end
        S_SCL_R: begin
          lres_q  <= scale_round(prod_q[SCL_BITS-1:0], l_q[SAMPLE_BITS-1]);
          prod_q  <= mul_p;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_q.left_out  <= lres_q.val;
            out_q.right_out <= rres.val;
            out_q.gain_now  <= g_q;
            out_q.ramping   <= trans_q;
            out_q.clipped   <= lres_q.clip || rres.clip;
            state_q         <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // A step moves the gain toward the target and never past it
  a_step_toward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPD |=> (up_q ? (g_q > $past(g_q) && g_q <= t_q)
                               : (g_q < $past(g_q) && g_q >= t_q)))
    else $error("gain step overshoots or stalls");

  // A jump lands on the target with no transition pending
  a_jump_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ERR && jump_q |-> !trans_q && g_q == t_q)
    else $error("jump did not set gain to target");

  // A result is only raised from the output state
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("result raised outside output state");

endmodule
